[sv/mvcf_pkg.sv]
// Shared types for the multiview color fusion block.
// Used by the front, queue, back and top-level modules; no dependencies.
package mvcf_pkg;

  localparam int unsigned NumChan = 3;

  typedef struct packed {
    logic       store;
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } mvcf_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CALC,
    ST_SEL,
    ST_DIV,
    ST_DONE
  } mvcf_state_e;

endpackage

[sv/mvcf_front.sv]
// Input stage: accepts view items, classifies them and registers them.
// Depends on mvcf_pkg for the item struct.
module mvcf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_view_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          red_i,
  input  logic                last_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output mvcf_pkg::mvcf_item_t push_item_o
);

  logic                 full_q, full_d;
  mvcf_pkg::mvcf_item_t item_q;
  logic                 acc;
  logic                 useful;

  // An item that neither stores a sample nor closes a point changes nothing.
  assign useful     = in_view_i | last_i;
  assign in_ready_o = !full_q || push_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    full_d = full_q;
    if (push_ready_i) begin
      full_d = 1'b0;
    end
    if (acc && useful) begin
      full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && useful) begin
      item_q.store <= in_view_i;
      item_q.last  <= last_i;
      item_q.blue  <= blue_i;
      item_q.green <= green_i;
      item_q.red   <= red_i;
    end
  end

  assign push_valid_o = full_q;
  assign push_item_o  = item_q;

endmodule

[sv/mvcf_queue.sv]
// Four-entry queue that decouples the input stage from the fusion engine.
// Depends on mvcf_pkg for the item struct.
module mvcf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  mvcf_pkg::mvcf_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output mvcf_pkg::mvcf_item_t pop_item_o
);

  mvcf_pkg::mvcf_item_t slots_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 3'd4);
  assign pop_valid_o  = (fill_q != 3'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 2'd1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 2'd1 : rd_ptr_q;
    fill_d   = fill_q + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      fill_q   <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[sv/mvcf_back.sv]
// Fusion engine: stores samples, then computes per-channel median or mean.
// Depends on mvcf_pkg for the item struct and the state enum.
module mvcf_back #(
  parameter int unsigned MaxViews = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 median_mode_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  mvcf_pkg::mvcf_item_t pop_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_red_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_blue_o
);

  localparam int unsigned AW  = (MaxViews > 1) ? $clog2(MaxViews) : 1;
  localparam int unsigned CW  = $clog2(MaxViews + 1);
  localparam int unsigned SW  = 8 + CW;
  localparam int unsigned DCW = $clog2(SW + 1);
  localparam int unsigned NC  = mvcf_pkg::NumChan;

  mvcf_pkg::mvcf_state_e state_q, state_d;

  logic [8*NC-1:0] mem [MaxViews];
  logic [8*NC-1:0] rdata_q;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [8*NC-1:0] wdata;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  rd_cnt_q, rd_cnt_d;
  logic           rdv_q, rdv_d;
  logic           pass_q, pass_d;
  logic [2:0]     bit_q, bit_d;
  logic [7:0]     pref_q [NC];
  logic [7:0]     pref_d [NC];
  logic [CW-1:0]  k_q [NC];
  logic [CW-1:0]  k_d [NC];
  logic [CW-1:0]  c_q [NC];
  logic [CW-1:0]  c_d [NC];
  logic [7:0]     lo_q [NC];
  logic [7:0]     lo_d [NC];
  logic [SW-1:0]  dvd_q [NC];
  logic [SW-1:0]  dvd_d [NC];
  logic [CW-1:0]  rem_q [NC];
  logic [CW-1:0]  rem_d [NC];
  logic [7:0]     res_q [NC];
  logic [7:0]     res_d [NC];
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           ovld_q, ovld_d;
  logic [7:0]     ored_q, ogrn_q, oblu_q;

  logic           pop;
  logic           issue;
  logic           sel_end;
  logic [7:0]     hmask;
  logic [CW-1:0]  r0, r1;
  logic [7:0]     smp [NC];
  logic [7:0]     npref [NC];
  logic           ge [NC];
  logic [CW:0]    remsh [NC];
  logic [8:0]     avg [NC];

  assign pop_ready_o = (state_q == mvcf_pkg::ST_LOAD);
  assign pop         = pop_valid_i && pop_ready_o;
  assign we          = pop && pop_item_i.store && (cnt_q < CW'(MaxViews));
  assign waddr       = cnt_q[AW-1:0];
  assign raddr       = rd_cnt_q[AW-1:0];
  assign wdata       = {pop_item_i.blue, pop_item_i.green, pop_item_i.red};
  assign issue       = (state_q == mvcf_pkg::ST_SEL) && (rd_cnt_q < cnt_q);
  assign sel_end     = (state_q == mvcf_pkg::ST_SEL) && (rd_cnt_q == cnt_q) && !rdv_q;
  assign r0          = (cnt_q - CW'(1)) >> 1;
  assign r1          = cnt_q >> 1;
  assign hmask       = 8'hFF << ({1'b0, bit_q} + 4'd1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mvcf_pkg::ST_LOAD: begin
        if (pop && pop_item_i.last) begin
          state_d = mvcf_pkg::ST_CALC;
        end
      end
      mvcf_pkg::ST_CALC: begin
        if (cnt_q == '0) begin
          state_d = mvcf_pkg::ST_DONE;
        end else if (median_mode_i) begin
          state_d = mvcf_pkg::ST_SEL;
        end else begin
          state_d = mvcf_pkg::ST_DIV;
        end
      end
      mvcf_pkg::ST_SEL: begin
        if (sel_end && bit_q == 3'd0 && pass_q) begin
          state_d = mvcf_pkg::ST_DONE;
        end
      end
      mvcf_pkg::ST_DIV: begin
        if (dcnt_q == DCW'(SW - 1)) begin
          state_d = mvcf_pkg::ST_DONE;
        end
      end
      mvcf_pkg::ST_DONE: begin
        if (!ovld_q || out_ready_i) begin
          state_d = mvcf_pkg::ST_LOAD;
        end
      end
      default: state_d = mvcf_pkg::ST_LOAD;
    endcase
  end

  // Datapath.
  always_comb begin
    cnt_d    = cnt_q;
    rd_cnt_d = rd_cnt_q;
    rdv_d    = issue;
    pass_d   = pass_q;
    bit_d    = bit_q;
    dcnt_d   = dcnt_q;
    ovld_d   = ovld_q;
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    for (int c = 0; c < NC; c++) begin
      smp[c]   = rdata_q[8*c +: 8];
      ge[c]    = (k_q[c] >= c_q[c]);
      npref[c] = pref_q[c] | (ge[c] ? (8'd1 << bit_q) : 8'd0);
      remsh[c] = {rem_q[c], dvd_q[c][SW-1]};
      avg[c]   = ({1'b0, lo_q[c]} + {1'b0, npref[c]}) >> 1;
      pref_d[c] = pref_q[c];
      k_d[c]    = k_q[c];
      c_d[c]    = c_q[c];
      lo_d[c]   = lo_q[c];
      dvd_d[c]  = dvd_q[c];
      rem_d[c]  = rem_q[c];
      res_d[c]  = res_q[c];
    end
    case (state_q)
      mvcf_pkg::ST_LOAD: begin
        if (we) begin
          cnt_d = cnt_q + CW'(1);
          for (int c = 0; c < NC; c++) begin
            dvd_d[c] = dvd_q[c] + SW'(wdata[8*c +: 8]);
          end
        end
      end
      mvcf_pkg::ST_CALC: begin
        rd_cnt_d = '0;
        pass_d   = 1'b0;
        bit_d    = 3'd7;
        dcnt_d   = '0;
        for (int c = 0; c < NC; c++) begin
          pref_d[c] = 8'd0;
          k_d[c]    = r0;
          c_d[c]    = '0;
          rem_d[c]  = '0;
          res_d[c]  = 8'd0;
        end
      end
      mvcf_pkg::ST_SEL: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + CW'(1);
        end
        for (int c = 0; c < NC; c++) begin
          if (rdv_q && ((smp[c] & hmask) == (pref_q[c] & hmask)) && !smp[c][bit_q]) begin
            c_d[c] = c_q[c] + CW'(1);
          end
        end
        if (sel_end) begin
          rd_cnt_d = '0;
          bit_d    = bit_q - 3'd1;
          for (int c = 0; c < NC; c++) begin
            c_d[c]    = '0;
            pref_d[c] = npref[c];
            k_d[c]    = ge[c] ? k_q[c] - c_q[c] : k_q[c];
            if (bit_q == 3'd0) begin
              if (!pass_q) begin
                lo_d[c]   = npref[c];
                pref_d[c] = 8'd0;
                k_d[c]    = r1;
              end else begin
                res_d[c] = avg[c][7:0];
              end
            end
          end
          if (bit_q == 3'd0) begin
            pass_d = 1'b1;
          end
        end
      end
      mvcf_pkg::ST_DIV: begin
        dcnt_d = dcnt_q + DCW'(1);
        for (int c = 0; c < NC; c++) begin
          if (remsh[c] >= {1'b0, cnt_q}) begin
            rem_d[c] = CW'(remsh[c] - {1'b0, cnt_q});
            dvd_d[c] = {dvd_q[c][SW-2:0], 1'b1};
          end else begin
            rem_d[c] = remsh[c][CW-1:0];
            dvd_d[c] = {dvd_q[c][SW-2:0], 1'b0};
          end
          if (dcnt_q == DCW'(SW - 1)) begin
            res_d[c] = dvd_d[c][7:0];
          end
        end
      end
      mvcf_pkg::ST_DONE: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d = 1'b1;
          cnt_d  = '0;
          for (int c = 0; c < NC; c++) begin
            dvd_d[c] = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mvcf_pkg::ST_LOAD;
      cnt_q    <= '0;
      rd_cnt_q <= '0;
      rdv_q    <= 1'b0;
      pass_q   <= 1'b0;
      bit_q    <= 3'd7;
      dcnt_q   <= '0;
      ovld_q   <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        dvd_q[c] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_cnt_q <= rd_cnt_d;
      rdv_q    <= rdv_d;
      pass_q   <= pass_d;
      bit_q    <= bit_d;
      dcnt_q   <= dcnt_d;
      ovld_q   <= ovld_d;
      for (int c = 0; c < NC; c++) begin
        dvd_q[c] <= dvd_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NC; c++) begin
      pref_q[c] <= pref_d[c];
      k_q[c]    <= k_d[c];
      c_q[c]    <= c_d[c];
      lo_q[c]   <= lo_d[c];
      rem_q[c]  <= rem_d[c];
      res_q[c]  <= res_d[c];
    end
    if (state_q == mvcf_pkg::ST_DONE && (!ovld_q || out_ready_i)) begin
      ored_q <= res_q[0];
      ogrn_q <= res_q[1];
      oblu_q <= res_q[2];
    end
  end

  assign out_valid_o = ovld_q;
  assign out_red_o   = ored_q;
  assign out_green_o = ogrn_q;
  assign out_blue_o  = oblu_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxViews))
    else $error("sample count above capacity");

  a_pop_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> state_q == mvcf_pkg::ST_LOAD)
    else $error("item taken while computing");

  a_rdv_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> state_q == mvcf_pkg::ST_SEL)
    else $error("sample read outside selection");

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvcf_pkg::ST_DONE && state_d == mvcf_pkg::ST_LOAD) |=> cnt_q == '0)
    else $error("sample count not cleared after a point");

endmodule

[sv/multiview_color_fusion_top.sv]
// Top level of the multiview color fusion block.
// Instantiates mvcf_front, mvcf_queue and mvcf_back; uses mvcf_pkg.
//
// Usage: one input item per camera view of a 3D point arrives on the s_axis
// channel; tlast marks the final view of the point, and tuser says whether
// the point is in that view. When the point closes, one fused color appears
// on the m_axis channel. The cfg channel writes median_mode (1 = median,
// 0 = truncated mean) and is always ready; write it only while idle.
// Timing: an input stage and a four-entry queue take items at one per cycle
// while the engine is loading; samples load into the sample memory one per
// cycle. On close, mean mode runs a restoring divider on the sum of
// 8+clog2(MAX+1) bits; median mode runs a bitwise rank selection of 16
// passes over the sample memory port. A point with no samples skips the
// computation and yields zero.
// Reset restores median mode, clears the sample count and empties the queue.
// When the receiver stalls, the result holds in the output register while
// further items fill the queue and input stage, then the input stalls.
module multiview_color_fusion_top #(
  parameter int unsigned MAX_VIEWS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue, green, red
  input  logic        s_axis_tuser,   // in_view
  input  logic        s_axis_tlast,   // last_view
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // out_red, out_green, out_blue
);

  logic                 median_mode_q;
  logic                 push_valid, push_ready;
  mvcf_pkg::mvcf_item_t push_item;
  logic                 pop_valid, pop_ready;
  mvcf_pkg::mvcf_item_t pop_item;
  logic [7:0]           out_red, out_green, out_blue;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      median_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      median_mode_q <= cfg_data_i;
    end
  end

  mvcf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_view_i    (s_axis_tuser),
    .blue_i       (s_axis_tdata[7:0]),
    .green_i      (s_axis_tdata[15:8]),
    .red_i        (s_axis_tdata[23:16]),
    .last_i       (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  mvcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  mvcf_back #(
    .MaxViews (MAX_VIEWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .median_mode_i (median_mode_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_red_o     (out_red),
    .out_green_o   (out_green),
    .out_blue_o    (out_blue)
  );

  assign m_axis_tdata = {out_blue, out_green, out_red};

endmodule

[dv/multiview_color_fusion_top_tb.sv]
// Testbench for multiview_color_fusion_top: streams per-view color samples,
// predicts the fused median or mean color of each point and checks it.
// Depends on the RTL top level only.
module multiview_color_fusion_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxViews = 32;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic       in_view;
    logic       last_view;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } view_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // blue, green, red
  logic        s_axis_tuser = 1'b0;  // in_view
  logic        s_axis_tlast = 1'b0;  // last_view
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // out_red, out_green, out_blue

  multiview_color_fusion_top #(.MAX_VIEWS(MaxViews)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  view_req_t view_queue[$];
  color_t    color_queue[$];
  logic [7:0] red_buf[MaxViews], green_buf[MaxViews], blue_buf[MaxViews];
  int unsigned view_count = 0;
  logic median_sel = 1'b1;
  int unsigned mismatches = 0, colors_seen = 0, views_sent = 0, idle_cycles = 0;
  bit quiet = 1'b1;  // no random idling while set
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;  // request accepted at the last rising edge

  function automatic logic [7:0] fuse_channel(input logic [7:0] vals[MaxViews],
                                              input int unsigned n);
    logic [7:0] sorted[$];
    int unsigned acc;
    acc = 0;
    if (n == 0) return 8'd0;
    if (!median_sel) begin
      for (int i = 0; i < n; i++) acc += vals[i];
      return 8'(acc / n);
    end
    for (int i = 0; i < n; i++) sorted = {sorted, vals[i]};
    sorted.sort();
    if (n % 2 == 0) return 8'((int'(sorted[n/2-1]) + int'(sorted[n/2])) / 2);
    return sorted[n/2];
  endfunction

  // Update the sample store for one accepted view; on the last view, queue the fused color.
  task automatic predict_fusion(input view_req_t v);
    color_t want_color;
    if (v.in_view && view_count < MaxViews) begin
      red_buf[view_count] = v.red;
      green_buf[view_count] = v.green;
      blue_buf[view_count] = v.blue;
      view_count++;
    end
    if (v.last_view) begin
      want_color = {fuse_channel(red_buf, view_count),
                    fuse_channel(green_buf, view_count),
                    fuse_channel(blue_buf, view_count)};
      color_queue = {color_queue, want_color};
      view_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) views_sent++;
      if (!s_axis_tvalid || in_taken) begin
        if (view_queue.size() > 0 && !hold_off && (quiet || $urandom_range(99) >= 36)) begin
          view_req_t v;
          v = view_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= v.in_view;
          s_axis_tlast <= v.last_view;
          s_axis_tdata <= {v.red, v.green, v.blue};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 36);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        predict_fusion({s_axis_tuser, s_axis_tlast, s_axis_tdata[7:0],
                        s_axis_tdata[15:8], s_axis_tdata[23:16]});
      if (m_axis_tvalid && m_axis_tready) begin
        colors_seen++;
        if (color_queue.size() == 0) begin
          report_mismatch("unexpected color", int'(m_axis_tdata), -1);
        end else begin
          color_t want, got;
          want = color_queue.pop_front();
          got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout with %0d colors outstanding", color_queue.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic add_view(input bit in_view, input bit last_view, input logic [7:0] b,
                          input logic [7:0] g, input logic [7:0] r);
    view_req_t v;
    v = {in_view, last_view, b, g, r};
    view_queue = {view_queue, v};
  endtask

  // Random point: mostly a handful of views, now and then more than the store holds.
  task automatic add_point();
    int unsigned n;
    n = ($urandom_range(19) == 0) ? $urandom_range(40, 33) : $urandom_range(8, 1);
    for (int i = 0; i < n; i++)
      add_view($urandom_range(99) < 80, i == n - 1, 8'($urandom), 8'($urandom),
               8'($urandom));
  endtask

  task automatic drain();
    while (view_queue.size() > 0 || s_axis_tvalid || color_queue.size() > 0)
      @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    median_sel = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed points in the reset mode (median).
    add_view(1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF);           // no samples
    add_view(1'b1, 1'b1, 8'hFF, 8'h00, 8'hA5);
    add_view(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF);           // even count
    add_view(1'b1, 1'b1, 8'hFE, 8'hFF, 8'h00);
    add_view(1'b1, 1'b0, 8'h10, 8'h80, 8'h01);
    add_view(1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    add_view(1'b1, 1'b0, 8'h20, 8'h7F, 8'hFF);
    add_view(1'b1, 1'b1, 8'h30, 8'h00, 8'h55);
    for (int i = 0; i < 36; i++)                         // too many views
      add_view(1'b1, i == 35, 8'(i * 7), 8'(255 - i), 8'(i * 13));
    drain();
    write_mode(1'b0);
    add_view(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    add_view(1'b1, 1'b0, 8'hFF, 8'hFE, 8'h00);
    add_view(1'b1, 1'b1, 8'hFE, 8'hFF, 8'h01);
    add_view(1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
    drain();
    quiet = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase[0]);
      while (view_queue.size() < 350) add_point();
      if (phase == 2) begin
        // Hold the sender until every queued color has arrived.
        wait (view_queue.size() < 175);
        hold_off = 1'b1;
        while (color_queue.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end
    quiet = 1'b1;
    write_mode(1'b1);
    repeat (20) add_point();
    drain();
    $display("Sent %0d view items and checked %0d fused colors", views_sent, colors_seen);
    $display("Covered median and mean modes, empty points and points past the view limit");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
